FILE: design/polar_to_cartesian_assert.svh
// ----------------------------------------------------------------------------
// polar_to_cartesian_assert.svh
// Assertion macros of the polar to cartesian converter. They expect
// signals named clock and reset in the scope where they are used.
// ----------------------------------------------------------------------------
`ifndef POLAR_TO_CARTESIAN_ASSERT_SVH
`define POLAR_TO_CARTESIAN_ASSERT_SVH

// same-cycle implication, checked outside of reset
`define PTC_ASSERT_IMPLIES(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("polar_to_cartesian: implication check failed");

// implication with a fixed delay, checked outside of reset
`define PTC_ASSERT_DELAYED(label, ante, dly, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> ##(dly) (cons)) \
      else $error("polar_to_cartesian: latency check failed");

`endif

FILE: design/ptc_pkg.sv
// ----------------------------------------------------------------------------
// ptc_pkg
// Types, constants and the arctangent table of the polar to cartesian
// converter.
// ----------------------------------------------------------------------------
package ptc_pkg;

   // number of rotation stages
   localparam int CORDIC_STEPS = 20;

   // residual angle in degrees with 16 fraction bits
   localparam int ZW = 25;

   // input angle has 7 fraction bits, residual angle has 16
   localparam int Z_SHIFT = 9;

   // reduced angle in [0, 360) degrees, 7 fraction bits
   localparam int RW = 16;

   // rotation results carry 24 fraction bits beyond Q8.8
   localparam int ROUND_SHIFT = 24;

   // reciprocal of the rotation gain, 24 fraction bits
   localparam logic [23:0] GAIN_Q24 = 24'd10188014;

   typedef logic [RW-1:0] turn_type;
   typedef logic signed [RW:0] sangle_type;

   // full, half and quarter turn at 7 fraction bits
   localparam sangle_type FULL_TURN    = 17'sd46080;
   localparam sangle_type HALF_TURN    = 17'sd23040;
   localparam sangle_type QUARTER_TURN = 17'sd11520;

   // largest residual angle after folding, 16 fraction bits
   localparam int Z_LIMIT = 11520 * 512;

   // control and angle carried along the rotation pipeline
   typedef struct packed {
      logic                 valid;
      logic signed [ZW-1:0] z;
   } stage_ctl_type;

   // atan(2^-step) in degrees, 16 fraction bits, rounded
   function automatic logic signed [ZW-1:0] atan_q16(input logic [4:0] step);
      logic signed [ZW-1:0] value;
      unique case (step)
         5'd0:    value = 25'sd2949120;
         5'd1:    value = 25'sd1740967;
         5'd2:    value = 25'sd919879;
         5'd3:    value = 25'sd466945;
         5'd4:    value = 25'sd234379;
         5'd5:    value = 25'sd117304;
         5'd6:    value = 25'sd58666;
         5'd7:    value = 25'sd29335;
         5'd8:    value = 25'sd14668;
         5'd9:    value = 25'sd7334;
         5'd10:   value = 25'sd3667;
         5'd11:   value = 25'sd1833;
         5'd12:   value = 25'sd917;
         5'd13:   value = 25'sd458;
         5'd14:   value = 25'sd229;
         5'd15:   value = 25'sd115;
         5'd16:   value = 25'sd57;
         5'd17:   value = 25'sd29;
         5'd18:   value = 25'sd14;
         5'd19:   value = 25'sd7;
         default: value = '0;
      endcase
      return value;
   endfunction

endpackage

FILE: design/ptc_cordic_stage.sv
// ----------------------------------------------------------------------------
// ptc_cordic_stage
// One registered CORDIC rotation: shift, add or subtract by the sign of the
// residual angle, and step the angle by the arctangent of this stage.
// ----------------------------------------------------------------------------
module ptc_cordic_stage #(
   parameter int XW   = 42,
   parameter int STEP = 0
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ptc_pkg::stage_ctl_type        in_ctl,
   input  logic signed [XW-1:0]          in_x,
   input  logic signed [XW-1:0]          in_y,
   output ptc_pkg::stage_ctl_type        out_ctl,
   output logic signed [XW-1:0]          out_x,
   output logic signed [XW-1:0]          out_y
);

   localparam logic signed [ptc_pkg::ZW-1:0] ATAN_STEP = ptc_pkg::atan_q16(5'(STEP));

   ptc_pkg::stage_ctl_type        ctl_in;
   logic                          valid_ff;
   logic signed [ptc_pkg::ZW-1:0] z_ff;
   logic signed [XW-1:0]          x_ff, x_in;
   logic signed [XW-1:0]          y_ff, y_in;
   logic signed [XW-1:0]          dx, dy;

   // rotate toward zero residual angle
   always_comb begin
      dx           = in_y >>> STEP;
      dy           = in_x >>> STEP;
      ctl_in.valid = in_ctl.valid;
      if (!in_ctl.z[ptc_pkg::ZW-1]) begin
         x_in     = in_x - dx;
         y_in     = in_y + dy;
         ctl_in.z = in_ctl.z - ATAN_STEP;
      end else begin
         x_in     = in_x + dx;
         y_in     = in_y - dy;
         ctl_in.z = in_ctl.z + ATAN_STEP;
      end
   end

   // valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= ctl_in.valid;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      z_ff <= ctl_in.z;
      x_ff <= x_in;
      y_ff <= y_in;
   end

   // stage outputs
   always_comb begin
      out_ctl.valid = valid_ff;
      out_ctl.z     = z_ff;
   end

   assign out_x   = x_ff;
   assign out_y   = y_ff;

endmodule

FILE: design/polar_to_cartesian.sv
// ----------------------------------------------------------------------------
// polar_to_cartesian
// Converts a signed Q8.8 radius and an angle in degrees into Q8.8 real and
// imaginary parts with a gain-compensated CORDIC pipeline.
// ----------------------------------------------------------------------------
// A request is taken on every clock where start is high; busy is always low,
// so one conversion enters per cycle. Each result sits on the rsp_ ports with
// rsp_valid high for one cycle, after its request has passed every register
// stage in order, and the receiver takes it then, since the result side cannot
// hold off. The 25 register stages are four of angle reduction and radius
// prescaling (reciprocal multiply, modulo correction, offset correction,
// quadrant fold), twenty rotation stages, and one rounding and saturation
// stage. Angles of any value wrap modulo 360 degrees; results are rounded to
// nearest and saturated.
// ----------------------------------------------------------------------------
`include "polar_to_cartesian_assert.svh"

module polar_to_cartesian #(
   parameter int MAG_WIDTH   = 16,
   parameter int ANGLE_WIDTH = 17
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [MAG_WIDTH-1:0]   req_magnitude,
   input  logic signed [ANGLE_WIDTH-1:0] req_angle_deg,
   output logic                          rsp_valid,
   output logic signed [MAG_WIDTH-1:0]   rsp_real_part,
   output logic signed [MAG_WIDTH-1:0]   rsp_imag_part
);

   localparam int STEPS   = ptc_pkg::CORDIC_STEPS;
   localparam int LATENCY = STEPS + 5;
   localparam int XW      = MAG_WIDTH + 26;
   localparam int SH      = ANGLE_WIDTH + 16;
   localparam int QW      = ANGLE_WIDTH + 1;
   localparam int PW      = SH + QW;
   localparam int QNW     = ANGLE_WIDTH + 17;

   // floor reciprocal of a full turn; quotient is exact or one low
   localparam logic [PW-1:0] RECIP = PW'((64'd1 << SH) / 64'd46080);

   // offset turns the biased angle back into the true angle modulo a turn
   localparam logic [16:0] MOD_CORR =
      17'((64'd46080 - ((64'd1 << (ANGLE_WIDTH - 1)) % 64'd46080)) % 64'd46080);

   localparam logic signed [XW-1:0] GAIN_X     = $signed(XW'(ptc_pkg::GAIN_Q24));
   localparam logic signed [XW-1:0] ROUND_BIAS = $signed(XW'(64'd1 << 23));

   logic req_accept;

   // stage 1: biased angle times reciprocal, radius times gain
   logic                      s1_valid_ff;
   logic [ANGLE_WIDTH-1:0]    s1_u_ff, s1_u_in;
   logic [PW-1:0]             s1_prod_ff, s1_prod_in;
   logic signed [XW-1:0]      s1_x_ff, s1_x_in;

   // stage 2: remainder modulo a full turn
   logic                      s2_valid_ff;
   ptc_pkg::turn_type         s2_r_ff, s2_r_in;
   logic signed [XW-1:0]      s2_x_ff;
   logic [QW-1:0]             s2_q;
   logic [QNW-1:0]            s2_qn;
   logic [QNW-1:0]            s2_diff;
   logic [16:0]               s2_r0;

   // stage 3: remove the bias
   logic                      s3_valid_ff;
   ptc_pkg::turn_type         s3_r_ff, s3_r_in;
   logic signed [XW-1:0]      s3_x_ff;
   logic [16:0]               s3_sum;

   // stage 4: fold into plus or minus 90 degrees
   logic                      s4_valid_ff;
   logic signed [ptc_pkg::ZW-1:0] s4_z_ff, s4_z_in;
   logic signed [XW-1:0]      s4_x_ff, s4_x_in;
   ptc_pkg::sangle_type       s4_ang, s4_fold;
   logic                      s4_neg;

   // rotation pipeline
   ptc_pkg::stage_ctl_type    c_ctl [0:STEPS];
   logic signed [XW-1:0]      c_x   [0:STEPS];
   logic signed [XW-1:0]      c_y   [0:STEPS];

   // output stage
   logic                      rsp_valid_ff;
   logic signed [MAG_WIDTH-1:0] rsp_real_ff, rsp_real_in;
   logic signed [MAG_WIDTH-1:0] rsp_imag_ff, rsp_imag_in;

   // pipeline never stalls
   assign busy       = 1'b0;
   assign req_accept = start && !busy;

   // round to nearest at Q8.8, then saturate to the output width
   function automatic logic signed [MAG_WIDTH-1:0] round_sat(input logic signed [XW-1:0] v);
      logic signed [XW-1:0]  sum;
      logic [MAG_WIDTH+1:0]  r;
      logic signed [MAG_WIDTH-1:0] res;
      sum = v + ROUND_BIAS;
      r   = sum[XW-1:ptc_pkg::ROUND_SHIFT];
      if (r[MAG_WIDTH+1:MAG_WIDTH-1] == 3'b000 || r[MAG_WIDTH+1:MAG_WIDTH-1] == 3'b111) begin
         res = r[MAG_WIDTH-1:0];
      end else if (r[MAG_WIDTH+1]) begin
         res = {1'b1, {(MAG_WIDTH-1){1'b0}}};
      end else begin
         res = {1'b0, {(MAG_WIDTH-1){1'b1}}};
      end
      return res;
   endfunction

   // stage 1 logic
   always_comb begin
      s1_u_in    = req_angle_deg ^ {1'b1, {(ANGLE_WIDTH-1){1'b0}}};
      s1_prod_in = PW'(s1_u_in) * RECIP;
      s1_x_in    = XW'(req_magnitude) * GAIN_X;
   end

   // stage 2 logic: quotient times a turn, one corrective subtract
   always_comb begin
      s2_q    = s1_prod_ff[PW-1:SH];
      s2_qn   = QNW'(s2_q) * QNW'(ptc_pkg::FULL_TURN);
      s2_diff = QNW'(s1_u_ff) - s2_qn;
      s2_r0   = s2_diff[16:0];
      if (s2_r0 >= 17'(ptc_pkg::FULL_TURN)) begin
         s2_r_in = ptc_pkg::turn_type'(s2_r0 - 17'(ptc_pkg::FULL_TURN));
      end else begin
         s2_r_in = s2_r0[ptc_pkg::RW-1:0];
      end
   end

   // stage 3 logic: add the bias correction and wrap once
   always_comb begin
      s3_sum = {1'b0, s2_r_ff} + MOD_CORR;
      if (s3_sum >= 17'(ptc_pkg::FULL_TURN)) begin
         s3_r_in = ptc_pkg::turn_type'(s3_sum - 17'(ptc_pkg::FULL_TURN));
      end else begin
         s3_r_in = s3_sum[ptc_pkg::RW-1:0];
      end
   end

   // stage 4 logic: map to [-180, 180), fold by half a turn, negate vector
   always_comb begin
      if ({1'b0, s3_r_ff} >= 17'(ptc_pkg::HALF_TURN)) begin
         s4_ang = $signed({1'b0, s3_r_ff}) - ptc_pkg::FULL_TURN;
      end else begin
         s4_ang = $signed({1'b0, s3_r_ff});
      end
      priority if (s4_ang > ptc_pkg::QUARTER_TURN) begin
         s4_fold = s4_ang - ptc_pkg::HALF_TURN;
         s4_neg  = 1'b1;
      end else if (s4_ang < -ptc_pkg::QUARTER_TURN) begin
         s4_fold = s4_ang + ptc_pkg::HALF_TURN;
         s4_neg  = 1'b1;
      end else begin
         s4_fold = s4_ang;
         s4_neg  = 1'b0;
      end
      s4_z_in = {{(ptc_pkg::ZW-ptc_pkg::RW-1){s4_fold[ptc_pkg::RW]}}, s4_fold} <<<
                ptc_pkg::Z_SHIFT;
      s4_x_in = s4_neg ? -s3_x_ff : s3_x_ff;
   end

   // valid bits of the front stages
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_accept;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   // payload of the front stages
   always_ff @(posedge clock) begin
      s1_u_ff    <= s1_u_in;
      s1_prod_ff <= s1_prod_in;
      s1_x_ff    <= s1_x_in;
      s2_r_ff    <= s2_r_in;
      s2_x_ff    <= s1_x_ff;
      s3_r_ff    <= s3_r_in;
      s3_x_ff    <= s2_x_ff;
      s4_z_ff    <= s4_z_in;
      s4_x_ff    <= s4_x_in;
   end

   // rotation pipeline entry
   assign c_ctl[0] = {s4_valid_ff, s4_z_ff};
   assign c_x[0]   = s4_x_ff;
   assign c_y[0]   = '0;

   // one registered rotation per step
   for (genvar i = 0; i < STEPS; i++) begin : g_rot
      ptc_cordic_stage #(
         .XW   (XW),
         .STEP (i)
      ) u_rot (
         .clock   (clock),
         .reset   (reset),
         .in_ctl  (c_ctl[i]),
         .in_x    (c_x[i]),
         .in_y    (c_y[i]),
         .out_ctl (c_ctl[i+1]),
         .out_x   (c_x[i+1]),
         .out_y   (c_y[i+1])
      );
   end

   // output rounding
   always_comb begin
      rsp_real_in = round_sat(c_x[STEPS]);
      rsp_imag_in = round_sat(c_y[STEPS]);
   end

   // response strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= c_ctl[STEPS].valid;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      rsp_real_ff <= rsp_real_in;
      rsp_imag_ff <= rsp_imag_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_real_part = rsp_real_ff;
   assign rsp_imag_part = rsp_imag_ff;

   // every response traces back to a request a fixed latency earlier
   `PTC_ASSERT_IMPLIES(a_rsp_has_req, rsp_valid, $past(req_accept, LATENCY))

   // every request gives a response after the fixed latency
   `PTC_ASSERT_DELAYED(a_req_gives_rsp, req_accept, LATENCY, rsp_valid)

   // angle reduction stays within one turn
   `PTC_ASSERT_IMPLIES(a_turn_range, s3_valid_ff, {1'b0, s3_r_ff} < 17'(ptc_pkg::FULL_TURN))

   // folded angle stays within a quarter turn
   `PTC_ASSERT_IMPLIES(a_fold_range, s4_valid_ff, s4_z_ff <= ptc_pkg::Z_LIMIT && s4_z_ff >= -ptc_pkg::Z_LIMIT)

endmodule

FILE: sim/polar_to_cartesian_tb.sv
// ----------------------------------------------------------------------------
// polar_to_cartesian_tb
// Self-checking bench for the polar to cartesian converter. Requests go in
// through the start/busy handshake with random gaps. Every accepted request is
// run through a behavioral CORDIC model held here, or through a value typed
// into the directed table, and each rsp_valid strobe is checked field by field
// against the oldest pending expectation.
// ----------------------------------------------------------------------------
module polar_to_cartesian_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MW = 16;
   localparam int AW = 17;

   // behavioral model constants: angles at 7 fraction bits
   localparam longint TURN_360   = 46080;
   localparam longint TURN_180   = 23040;
   localparam longint TURN_90    = 11520;
   localparam longint INV_GAIN   = 10188014;
   localparam int     ROTATIONS  = 20;
   localparam int     NUM_RANDOM = 1330;
   localparam int     DRAIN_WAIT = 40;
   localparam int     CYCLE_LIMIT = 400000;

   // arctangent of 2^-i in degrees, 16 fraction bits
   localparam longint ATAN_DEG [ROTATIONS] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7
   };

   typedef struct {
      logic signed [MW-1:0] real_part;
      logic signed [MW-1:0] imag_part;
   } cart_point_type;

   typedef struct {
      int magnitude;
      int angle_deg;
      bit known;
      int real_part;
      int imag_part;
   } polar_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [MW-1:0] req_magnitude = '0;
   logic signed [AW-1:0] req_angle_deg = '0;
   logic rsp_valid;
   logic signed [MW-1:0] rsp_real_part;
   logic signed [MW-1:0] rsp_imag_part;

   cart_point_type pending_cart[$];
   int error_count = 0;
   int cycle_count = 0;
   int calm_left = 0;

   // directed requests: extremes, quadrant folds, wrap-around
   polar_row_type directed_rows [22] = '{
      '{0,      0,      1'b1, 0,      0},
      '{0,      46080,  1'b1, 0,      0},
      '{32767,  0,      1'b1, 32767,  0},
      '{-32768, 0,      1'b1, -32768, 0},
      '{-32768, 23040,  1'b1, 32767,  0},   // most negative radius at 180 deg
      '{32767,  -23040, 1'b0, 0,      0},   // exactly -180 deg
      '{256,    11520,  1'b0, 0,      0},
      '{256,    -11520, 1'b0, 0,      0},
      '{256,    11521,  1'b0, 0,      0},
      '{256,    -11521, 1'b0, 0,      0},
      '{32767,  23039,  1'b0, 0,      0},
      '{-32768, -23041, 1'b0, 0,      0},
      '{1000,   46080,  1'b0, 0,      0},
      '{1000,   -46080, 1'b0, 0,      0},
      '{1000,   65535,  1'b0, 0,      0},   // beyond 360 deg, wraps
      '{1000,   -65536, 1'b0, 0,      0},
      '{32767,  5760,   1'b0, 0,      0},
      '{-32768, 17280,  1'b0, 0,      0},
      '{1,      0,      1'b0, 0,      0},
      '{-1,     0,      1'b0, 0,      0},
      '{32767,  -34560, 1'b0, 0,      0},
      '{12345,  34560,  1'b0, 0,      0}
   };

   polar_to_cartesian #(
      .MAG_WIDTH   (MW),
      .ANGLE_WIDTH (AW)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_magnitude (req_magnitude),
      .req_angle_deg (req_angle_deg),
      .rsp_valid     (rsp_valid),
      .rsp_real_part (rsp_real_part),
      .rsp_imag_part (rsp_imag_part)
   );

   // clock generation
   initial begin
      forever #5 clock = ~clock;
   end

   // round to nearest out of 24 extra fraction bits, then saturate
   function automatic logic signed [MW-1:0] round_q88(input longint v);
      longint r;
      r = (v + 64'sd8388608) >>> 24;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return r[MW-1:0];
   endfunction

   // wrap, fold to +-90 deg, rotate with prescaled radius
   function automatic cart_point_type rotate_polar(input logic signed [MW-1:0] mag,
                                                   input logic signed [AW-1:0] ang);
      longint a;
      longint x;
      longint y;
      longint z;
      longint dx;
      longint dy;
      cart_point_type p;
      a = longint'(ang) % TURN_360;
      if (a < 0) a += TURN_360;
      if (a >= TURN_180) a -= TURN_360;
      x = longint'(mag) * INV_GAIN;
      if (a > TURN_90) begin
         a -= TURN_180;
         x = -x;
      end else if (a < -TURN_90) begin
         a += TURN_180;
         x = -x;
      end
      y = 0;
      z = a * 512;
      for (int i = 0; i < ROTATIONS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx;
            y += dy;
            z -= ATAN_DEG[i];
         end else begin
            x += dx;
            y -= dy;
            z += ATAN_DEG[i];
         end
      end
      p.real_part = round_q88(x);
      p.imag_part = round_q88(y);
      return p;
   endfunction

   // mostly short gaps, a few long, with calm stretches of back-to-back requests
   function automatic int next_gap();
      int sel;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      sel = $urandom_range(0, 99);
      if (sel < 3) begin
         calm_left = $urandom_range(20, 80);
         return 0;
      end
      if (sel < 50) return 0;
      if (sel < 85) return $urandom_range(1, 3);
      if (sel < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic signed [MW-1:0] random_magnitude();
      int sel;
      int extremes [5] = '{32767, -32768, 0, 1, -1};
      sel = $urandom_range(0, 99);
      if (sel < 70) return MW'($urandom());
      if (sel < 80) return MW'(extremes[$urandom_range(0, 4)]);
      if (sel < 95) return MW'(int'($urandom_range(0, 2048)) - 1024);
      if (sel < 97) return MW'(32767 - int'($urandom_range(0, 15)));
      return MW'(-32768 + int'($urandom_range(0, 15)));
   endfunction

   // mostly in range, some near quadrant edges, some using the full field
   function automatic logic signed [AW-1:0] random_angle();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 55) return AW'(int'($urandom_range(0, 92160)) - 46080);
      if (sel < 80)
         return AW'((int'($urandom_range(0, 8)) - 4) * 11520 + int'($urandom_range(0, 6)) - 3);
      if (sel < 90) return AW'(int'($urandom_range(0, 512)) - 256);
      return AW'($urandom());
   endfunction

   task automatic report_mismatch(input string what, input int want, input int got);
      error_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
   endtask

   // issue one request, wait for it to be taken, record its expected result
   task automatic send_request(input logic signed [MW-1:0] mag,
                               input logic signed [AW-1:0] ang,
                               input bit known,
                               input cart_point_type typed);
      int gap;
      start <= 1'b1;
      req_magnitude <= mag;
      req_angle_deg <= ang;
      do @(posedge clock); while (busy);
      pending_cart.push_back(known ? typed : rotate_polar(mag, ang));
      gap = next_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // stimulus
   initial begin
      cart_point_type typed;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      foreach (directed_rows[r]) begin
         typed.real_part = MW'(directed_rows[r].real_part);
         typed.imag_part = MW'(directed_rows[r].imag_part);
         send_request(MW'(directed_rows[r].magnitude), AW'(directed_rows[r].angle_deg),
                      directed_rows[r].known, typed);
      end

      // random requests
      for (int n = 0; n < NUM_RANDOM; n++) begin
         send_request(random_magnitude(), random_angle(), 1'b0, typed);
      end
      start <= 1'b0;

      // drain
      while (pending_cart.size() > 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // result checker
   always @(posedge clock) begin
      cart_point_type want;
      if (!reset && rsp_valid) begin
         if (pending_cart.size() == 0) begin
            report_mismatch("unexpected result, real_part", 0, int'(rsp_real_part));
         end else begin
            want = pending_cart.pop_front();
            if (rsp_real_part !== want.real_part)
               report_mismatch("real_part", int'(want.real_part), int'(rsp_real_part));
            if (rsp_imag_part !== want.imag_part)
               report_mismatch("imag_part", int'(want.imag_part), int'(rsp_imag_part));
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d results still pending", $time, pending_cart.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

endmodule

FILE: sim.f
+incdir+design
design/ptc_pkg.sv
design/ptc_cordic_stage.sv
design/polar_to_cartesian.sv
sim/polar_to_cartesian_tb.sv
